FILE: design/lcgr_pkg.sv
// lcgr_pkg: types, constants and preset tables shared by the LCG random unit.
// No dependencies; every other design file uses it by scoped names.
`default_nettype none
package lcgr_pkg;

  localparam int unsigned PC_W   = 5;
  localparam int unsigned IN_W   = 104;  // 98 payload bits padded to whole bytes
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned CNT_W  = 6;
  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd32;

  // request operation codes
  localparam logic [1:0] OPER_RAW   = 2'd0;
  localparam logic [1:0] OPER_LIMIT = 2'd1;
  localparam logic [1:0] OPER_RANGE = 2'd2;

  // config register indexes
  localparam logic REG_PRESET = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  localparam logic [1:0] PRESET_GLIBC  = 2'd1;
  localparam logic [1:0] PRESET_GLIBC31 = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] SPAN_LIM = 32'h7FFF_FFFF;  // diff at or above this is too wide

  // datapath micro-ops
  typedef enum logic [3:0] {
    D_NOP,
    D_MUL,       // prod = state * A
    D_ADD,       // state = draw = (prod + B) & mask
    D_DIV_THR,   // load divider: all ones / limit
    D_DIV_LIM,   // load divider: draw / limit
    D_DIV_RNG,   // load divider: draw / span
    D_DIV_STEP,  // one restoring division step
    D_THR,       // thr = all ones - remainder
    D_OUT_RAW,
    D_OUT_REM,
    D_OUT_RNG,
    D_OUT_ERR
  } dp_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_ERR,
    C_LIM,
    C_RNG,
    C_DIV_MORE,
    C_GE_THR
  } cond_t;

  typedef struct packed {
    dp_op_t          op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ctrl_t;

  typedef struct packed {
    logic err;
    logic op_lim;
    logic op_rng;
    logic div_more;
    logic ge_thr;
  } flags_t;

  // microcode entry points
  localparam logic [PC_W-1:0] PC_RAW  = 5'd3;
  localparam logic [PC_W-1:0] PC_LIM  = 5'd6;
  localparam logic [PC_W-1:0] PC_LDIV = 5'd7;
  localparam logic [PC_W-1:0] PC_DRAW = 5'd9;
  localparam logic [PC_W-1:0] PC_MDIV = 5'd13;
  localparam logic [PC_W-1:0] PC_RNG  = 5'd15;
  localparam logic [PC_W-1:0] PC_RDIV = 5'd18;
  localparam logic [PC_W-1:0] PC_ERR  = 5'd20;

  function automatic logic [31:0] preset_mul(input logic [1:0] p);
    logic [31:0] m;
    m = 32'd214013;
    if (p == PRESET_GLIBC || p == PRESET_GLIBC31) m = 32'd1103515245;
    return m;
  endfunction

  function automatic logic [31:0] preset_inc(input logic [1:0] p);
    logic [31:0] c;
    c = 32'd2531011;
    if (p == PRESET_GLIBC || p == PRESET_GLIBC31) c = 32'd12345;
    return c;
  endfunction

  function automatic logic [31:0] preset_mask(input logic [1:0] p);
    logic [31:0] k;
    k = ALL_ONES;
    if (p == PRESET_GLIBC31) k = 32'h7FFF_FFFF;
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: design/lcgr_rom.sv
// lcgr_rom: microcode table, one control word per step.
// Depends on lcgr_pkg.
`default_nettype none
module lcgr_rom (
  input  wire logic [lcgr_pkg::PC_W-1:0] addr,
  output lcgr_pkg::ctrl_t                ctrl
);

  always_comb begin
    ctrl = '{op: lcgr_pkg::D_NOP, cond: lcgr_pkg::C_NEVER, target: '0, done: 1'b0};
    case (addr)
      // dispatch
      5'd0:  ctrl = '{lcgr_pkg::D_NOP, lcgr_pkg::C_ERR, lcgr_pkg::PC_ERR, 1'b0};
      5'd1:  ctrl = '{lcgr_pkg::D_NOP, lcgr_pkg::C_LIM, lcgr_pkg::PC_LIM, 1'b0};
      5'd2:  ctrl = '{lcgr_pkg::D_NOP, lcgr_pkg::C_RNG, lcgr_pkg::PC_RNG, 1'b0};
      // raw draw
      5'd3:  ctrl = '{lcgr_pkg::D_MUL, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd4:  ctrl = '{lcgr_pkg::D_ADD, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd5:  ctrl = '{lcgr_pkg::D_OUT_RAW, lcgr_pkg::C_NEVER, '0, 1'b1};
      // limit: threshold, rejection loop, modulo
      5'd6:  ctrl = '{lcgr_pkg::D_DIV_THR, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd7:  ctrl = '{lcgr_pkg::D_DIV_STEP, lcgr_pkg::C_DIV_MORE, lcgr_pkg::PC_LDIV, 1'b0};
      5'd8:  ctrl = '{lcgr_pkg::D_THR, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd9:  ctrl = '{lcgr_pkg::D_MUL, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd10: ctrl = '{lcgr_pkg::D_ADD, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd11: ctrl = '{lcgr_pkg::D_NOP, lcgr_pkg::C_GE_THR, lcgr_pkg::PC_DRAW, 1'b0};
      5'd12: ctrl = '{lcgr_pkg::D_DIV_LIM, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd13: ctrl = '{lcgr_pkg::D_DIV_STEP, lcgr_pkg::C_DIV_MORE, lcgr_pkg::PC_MDIV, 1'b0};
      5'd14: ctrl = '{lcgr_pkg::D_OUT_REM, lcgr_pkg::C_NEVER, '0, 1'b1};
      // range
      5'd15: ctrl = '{lcgr_pkg::D_MUL, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd16: ctrl = '{lcgr_pkg::D_ADD, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd17: ctrl = '{lcgr_pkg::D_DIV_RNG, lcgr_pkg::C_NEVER, '0, 1'b0};
      5'd18: ctrl = '{lcgr_pkg::D_DIV_STEP, lcgr_pkg::C_DIV_MORE, lcgr_pkg::PC_RDIV, 1'b0};
      5'd19: ctrl = '{lcgr_pkg::D_OUT_RNG, lcgr_pkg::C_NEVER, '0, 1'b1};
      // error result
      5'd20: ctrl = '{lcgr_pkg::D_OUT_ERR, lcgr_pkg::C_NEVER, '0, 1'b1};
      default: ctrl = '{lcgr_pkg::D_OUT_ERR, lcgr_pkg::C_NEVER, '0, 1'b1};
    endcase
  end

endmodule
`default_nettype wire

FILE: design/lcgr_seq.sv
// lcgr_seq: step counter with conditional jumps over the microcode table.
// Depends on lcgr_pkg.
`default_nettype none
module lcgr_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      stall,
  input  wire lcgr_pkg::ctrl_t           ctrl,
  input  wire lcgr_pkg::flags_t          flags,
  output logic [lcgr_pkg::PC_W-1:0]      pc,
  output logic                           busy
);

  logic [lcgr_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      busy_r, busy_nxt;
  logic                      take;

  always_comb begin
    case (ctrl.cond)
      lcgr_pkg::C_NEVER:    take = 1'b0;
      lcgr_pkg::C_ALWAYS:   take = 1'b1;
      lcgr_pkg::C_ERR:      take = flags.err;
      lcgr_pkg::C_LIM:      take = flags.op_lim;
      lcgr_pkg::C_RNG:      take = flags.op_rng;
      lcgr_pkg::C_DIV_MORE: take = flags.div_more;
      lcgr_pkg::C_GE_THR:   take = flags.ge_thr;
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (!stall) begin
      if (ctrl.done) begin
        busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = ctrl.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign pc   = pc_r;
  assign busy = busy_r;

endmodule
`default_nettype wire

FILE: design/lcgr_dpath.sv
// lcgr_dpath: generator state, multiplier, restoring divider and result mux.
// Depends on lcgr_pkg; driven one micro-op per cycle by the sequencer, except while the result step is stalled.
`default_nettype none
module lcgr_dpath (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire logic [1:0]   operation,
  input  wire logic [31:0]  limit_value,
  input  wire logic [31:0]  range_low,
  input  wire logic [31:0]  range_high,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_wr_data,
  input  wire logic         step_en,
  input  wire lcgr_pkg::ctrl_t ctrl,
  output lcgr_pkg::flags_t  flags,
  output logic [31:0]       res_number,
  output logic              res_status
);

  logic [1:0]  preset_r;
  logic [31:0] state_r, prod_r, draw_r, thr_r;
  logic [31:0] lim_r, lo_r, span_r;
  logic        err_r, op_lim_r, op_rng_r;
  logic [31:0] rem_r, dvd_r, dvsr_r;
  logic [lcgr_pkg::CNT_W-1:0] cnt_r;

  logic [32:0] diff;
  logic        err_nxt;
  logic [32:0] shifted, trial;
  logic [31:0] state_nxt;

  // signed hi - lo in 33 bits: negative means inverted range
  assign diff = {range_high[31], range_high} - {range_low[31], range_low};

  always_comb begin
    err_nxt = 1'b0;
    case (operation)
      lcgr_pkg::OPER_RAW:   err_nxt = 1'b0;
      lcgr_pkg::OPER_LIMIT: err_nxt = (limit_value == '0);
      lcgr_pkg::OPER_RANGE: err_nxt = diff[32] || (diff[31:0] >= lcgr_pkg::SPAN_LIM);
      default:              err_nxt = 1'b1;
    endcase
  end

  assign shifted   = {rem_r, dvd_r[31]};
  assign trial     = shifted - {1'b0, dvsr_r};
  assign state_nxt = (prod_r + lcgr_pkg::preset_inc(preset_r))
                     & lcgr_pkg::preset_mask(preset_r);

  // request operands
  always_ff @(posedge clk) begin
    if (load) begin
      lim_r    <= limit_value;
      lo_r     <= range_low;
      span_r   <= diff[31:0] + 32'd1;
      err_r    <= err_nxt;
      op_lim_r <= (operation == lcgr_pkg::OPER_LIMIT);
      op_rng_r <= (operation == lcgr_pkg::OPER_RANGE);
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r <= '0;
      state_r  <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == lcgr_pkg::REG_PRESET) preset_r <= cfg_wr_data[1:0];
      else                                   state_r  <= cfg_wr_data;
    end else if (step_en && ctrl.op == lcgr_pkg::D_ADD) begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (step_en) begin
      case (ctrl.op)
        lcgr_pkg::D_MUL: prod_r <= state_r * lcgr_pkg::preset_mul(preset_r);
        lcgr_pkg::D_ADD: draw_r <= state_nxt;
        lcgr_pkg::D_DIV_THR: begin
          rem_r  <= '0;
          dvd_r  <= lcgr_pkg::ALL_ONES;
          dvsr_r <= lim_r;
          cnt_r  <= lcgr_pkg::DIV_STEPS;
        end
        lcgr_pkg::D_DIV_LIM: begin
          rem_r  <= '0;
          dvd_r  <= draw_r;
          dvsr_r <= lim_r;
          cnt_r  <= lcgr_pkg::DIV_STEPS;
        end
        lcgr_pkg::D_DIV_RNG: begin
          rem_r  <= '0;
          dvd_r  <= draw_r;
          dvsr_r <= span_r;
          cnt_r  <= lcgr_pkg::DIV_STEPS;
        end
        lcgr_pkg::D_DIV_STEP: begin
          rem_r <= trial[32] ? shifted[31:0] : trial[31:0];
          dvd_r <= {dvd_r[30:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
        end
        lcgr_pkg::D_THR: thr_r <= lcgr_pkg::ALL_ONES - rem_r;
        default: ;
      endcase
    end
  end

  assign flags = '{err:      err_r,
                   op_lim:   op_lim_r,
                   op_rng:   op_rng_r,
                   div_more: (cnt_r != {{(lcgr_pkg::CNT_W-1){1'b0}}, 1'b1}),
                   ge_thr:   (draw_r >= thr_r)};

  always_comb begin
    res_number = '0;
    res_status = 1'b0;
    case (ctrl.op)
      lcgr_pkg::D_OUT_RAW: res_number = draw_r;
      lcgr_pkg::D_OUT_REM: res_number = rem_r;
      lcgr_pkg::D_OUT_RNG: res_number = lo_r + rem_r;
      lcgr_pkg::D_OUT_ERR: res_status = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/lcg_random_with_range_modes_unit.sv
// lcg_random_with_range_modes_unit: microcoded LCG random number unit, top level.
// Depends on lcgr_pkg, lcgr_rom, lcgr_seq and lcgr_dpath.
//
//  port group | dir | contents
//  -----------+-----+-------------------------------------------------------------
//  in_*       | in  | request: tdata = operation, limit_value, range_low, range_high
//  out_*      | out | result: tdata = number, tuser = status
//  cfg_*      | in  | register write: index 0 preset, index 1 seed_value
//
// Sequencer steps per request: raw draws once; range draws and runs one 32-step
// divide; error goes straight to the result step; limit runs two 32-step divides,
// the first for the rejection threshold, and draws again on each rejected draw.
// Steps run one per clock except a stalled result step; the divider is single-bit restoring.
// Reset (rst_n low, synchronous) clears state, preset, sequencer and output valid.
// in_tready is high while the sequencer is idle. A finished result sits in the
// output register; a new request may be taken meanwhile, and its result step
// holds until the output register is free.
`default_nettype none
module lcg_random_with_range_modes_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [1:0] operation, [33:2] limit_value, [65:34] range_low, [97:66] range_high
  input  wire logic [lcgr_pkg::IN_W-1:0]  in_tdata,
  // result channel
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [31:0] number
  output logic [lcgr_pkg::OUT_W-1:0]      out_tdata,
  // [0] status
  output logic                            out_tuser,
  // config write port
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [31:0]                cfg_wr_data
);

  logic [lcgr_pkg::PC_W-1:0] pc;
  logic                      busy;
  lcgr_pkg::ctrl_t           ctrl;
  lcgr_pkg::flags_t          flags;
  logic                      load, stall, step_en;
  logic [31:0]               res_number;
  logic                      res_status;

  logic                      out_valid_r, out_valid_nxt;
  logic [31:0]               out_data_r;
  logic                      out_user_r;
  logic                      res_write;

  assign in_tready = !busy;
  assign load      = in_tvalid && in_tready;

  // result step waits while the output register still holds an untaken result
  assign stall     = ctrl.done && out_valid_r && !out_tready;
  assign step_en   = busy && !stall;
  assign res_write = step_en && ctrl.done;

  lcgr_rom u_rom (
    .addr (pc),
    .ctrl (ctrl)
  );

  lcgr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (load),
    .stall (stall),
    .ctrl  (ctrl),
    .flags (flags),
    .pc    (pc),
    .busy  (busy)
  );

  lcgr_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .operation   (in_tdata[1:0]),
    .limit_value (in_tdata[33:2]),
    .range_low   (in_tdata[65:34]),
    .range_high  (in_tdata[97:66]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .ctrl        (ctrl),
    .flags       (flags),
    .res_number  (res_number),
    .res_status  (res_status)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (res_write)                 out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      out_data_r <= res_number;
      out_user_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

FILE: tb/sv/lcg_random_with_range_modes_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lcg_random_with_range_modes_unit: directed and random requests
// in raw, limit and range modes under all preset codes, checked by an in-bench LCG model.
// Depends on lcgr_pkg and the unit's RTL only.
module lcg_random_with_range_modes_unit_tb;

  // codes the package leaves unnamed
  localparam logic [1:0] OPER_UNUSED  = 2'd3;  // always flagged
  localparam logic [1:0] PRESET_MSVC  = 2'd0;
  localparam logic [1:0] PRESET_ALIAS = 2'd3;  // unused preset code, acts as preset 0

  localparam logic [31:0] MUL_MSVC  = 32'd214013;
  localparam logic [31:0] INC_MSVC  = 32'd2531011;
  localparam logic [31:0] MUL_GLIBC = 32'd1103515245;
  localparam logic [31:0] INC_GLIBC = 32'd12345;
  localparam logic [31:0] MASK31    = 32'h7FFF_FFFF;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;   // long output stall, fills the unit
  localparam int DRAIN_CYCLES = 300;   // > slowest request (limit mode, several retries)
  localparam int PHASE_ITEMS  = 50;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    logic [31:0] number;
    logic        status;
  } lcg_result_t;

  // Generator state tracker: predicts each result and keeps the in-flight expectations.
  class lcg_draw_tracker;
    logic [31:0] gen_state;
    logic [1:0]  preset_sel;
    lcg_result_t expected_q[$];
    int mismatches;
    int requests;
    int checked;
    int error_results;
    int rejected_draws;

    function new();
      gen_state  = '0;
      preset_sel = PRESET_MSVC;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == lcgr_pkg::REG_PRESET) preset_sel = val[1:0];
      else gen_state = val;
    endfunction

    function logic [31:0] next_draw();
      logic [31:0] mul;
      logic [31:0] inc;
      logic [31:0] mask;
      mul  = MUL_GLIBC;
      inc  = INC_GLIBC;
      mask = lcgr_pkg::ALL_ONES;
      case (preset_sel)
        lcgr_pkg::PRESET_GLIBC:   mask = lcgr_pkg::ALL_ONES;
        lcgr_pkg::PRESET_GLIBC31: mask = MASK31;
        default: begin
          mul = MUL_MSVC;
          inc = INC_MSVC;
        end
      endcase
      gen_state = (mul * gen_state + inc) & mask;
      return gen_state;
    endfunction

    function lcg_result_t predict_result(logic [lcgr_pkg::IN_W-1:0] req);
      logic [1:0]  op;
      logic [31:0] lim;
      logic [31:0] thr;
      logic [31:0] d;
      longint      lo;
      longint      hi;
      longint      span;
      longint      d64;
      longint      sum;
      lcg_result_t r;
      op  = req[1:0];
      lim = req[33:2];
      lo  = longint'(signed'(req[65:34]));
      hi  = longint'(signed'(req[97:66]));
      // error by default: number zero, state untouched
      r.number = '0;
      r.status = 1'b1;
      case (op)
        lcgr_pkg::OPER_RAW: begin
          r.number = next_draw();
          r.status = 1'b0;
        end
        lcgr_pkg::OPER_LIMIT: begin
          if (lim != '0) begin
            thr = (lcgr_pkg::ALL_ONES / lim) * lim;
            d   = next_draw();
            while (d >= thr) begin
              rejected_draws++;
              d = next_draw();
            end
            r.number = d % lim;
            r.status = 1'b0;
          end
        end
        lcgr_pkg::OPER_RANGE: begin
          span = hi - lo + 1;
          if (lo <= hi && span <= 64'sd2147483647) begin
            d64      = next_draw();
            sum      = lo + d64 % span;
            r.number = sum[31:0];
            r.status = 1'b0;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [lcgr_pkg::IN_W-1:0] req);
      lcg_result_t e;
      e = predict_result(req);
      expected_q.push_back(e);
      requests++;
      if (e.status) error_results++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 20)
        $display("[%0t] mismatch on %s at result %0d: expected %h, got %h",
                 $time, what, checked, exp_v, got_v);
    endtask

    task check_result(logic [31:0] number, logic status);
      lcg_result_t e;
      if (expected_q.size() == 0) begin
        report("unrequested result", '0, number);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (status !== e.status) report("status", 32'(e.status), 32'(status));
      if (number !== e.number) report("number", e.number, number);
    endtask
  endclass

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  // [1:0] operation, [33:2] limit_value, [65:34] range_low, [97:66] range_high, rest 0
  logic [lcgr_pkg::IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  // [31:0] number
  logic [lcgr_pkg::OUT_W-1:0] out_tdata;
  // [0] status
  logic             out_tuser;
  logic             cfg_wr_en   = 1'b0;
  logic             cfg_index   = lcgr_pkg::REG_PRESET;
  logic [31:0]      cfg_wr_data = '0;

  lcg_draw_tracker tracker = new();
  int  cycle_count = 0;
  bit  calm        = 1'b0;  // no idling on either side while set
  bit  hold_req    = 1'b0;  // asks the receiver for one long stall
  bit  hold_done   = 1'b0;

  lcg_random_with_range_modes_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a stuck handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Handshake monitor. Samples are pre-edge values, so order within the step is moot.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tracker.note_request(in_tdata);
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
  end

  // Result receiver: random backpressure, a calm stretch, and one long hold-off
  // counted here while the sender keeps offering requests.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // Offer one request, with an occasional idle gap first; returns at the accepting edge.
  task automatic issue(logic [1:0] op, logic [31:0] lim, logic [31:0] lo, logic [31:0] hi);
    int gap;
    if (!calm && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(lcgr_pkg::IN_W-98){1'b0}}, hi, lo, lim, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly valid requests with random content; some zero limits, inverted and
  // too-wide ranges, and the unused operation code.
  task automatic random_request();
    logic [1:0]  op;
    logic [31:0] lim;
    logic [31:0] lo;
    logic [31:0] hi;
    longint      h;
    int          pick;
    lim  = $urandom;
    lo   = $urandom;
    hi   = $urandom;
    pick = $urandom_range(0, 99);
    op = (pick < 30) ? lcgr_pkg::OPER_RAW : (pick < 60) ? lcgr_pkg::OPER_LIMIT :
         (pick < 92) ? lcgr_pkg::OPER_RANGE : OPER_UNUSED;
    if (op == lcgr_pkg::OPER_LIMIT) begin
      case ($urandom_range(0, 4))
        0: lim = $urandom_range(1, 100);
        1: lim = 32'h8000_0000 + $urandom_range(0, 255);  // heavy rejection
        2: lim = lcgr_pkg::ALL_ONES - $urandom_range(0, 255);
        3: if ($urandom_range(0, 3) == 0) lim = '0;
        default: ;
      endcase
    end else if (op == lcgr_pkg::OPER_RANGE) begin
      case ($urandom_range(0, 5))
        0, 1, 2: h = longint'(signed'(lo)) + $urandom_range(0, 1000);
        3:       h = longint'(signed'(lo)) + $urandom_range(0, 32'h7FFF_FFFF);
        4:       h = longint'(signed'(hi));                 // mostly wide or inverted
        default: h = longint'(signed'(lo)) - $urandom_range(1, 1000);
      endcase
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      hi = h[31:0];
    end
    issue(op, lim, lo, hi);
  endtask

  // Hold the sender until every outstanding result is back; ends on a rising edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    @(posedge clk);
  endtask

  // Register writes, only with the unit idle. Preset writes carry junk above bit 1.
  task automatic set_regs(bit wr_preset, logic [1:0] p, bit wr_seed, logic [31:0] s);
    logic [31:0] pdata;
    if (wr_preset) begin
      pdata      = $urandom;
      pdata[1:0] = p;
      cfg_wr_en   <= 1'b1;
      cfg_index   <= lcgr_pkg::REG_PRESET;
      cfg_wr_data <= pdata;
      tracker.write_reg(lcgr_pkg::REG_PRESET, pdata);
      @(posedge clk);
    end
    if (wr_seed) begin
      cfg_wr_en   <= 1'b1;
      cfg_index   <= lcgr_pkg::REG_SEED;
      cfg_wr_data <= s;
      tracker.write_reg(lcgr_pkg::REG_SEED, s);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int ph;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset state (preset 0, state 0), field extremes and every error case.
    issue(lcgr_pkg::OPER_RAW,    $urandom, $urandom, $urandom);
    issue(lcgr_pkg::OPER_RAW,    $urandom, $urandom, $urandom);
    issue(lcgr_pkg::OPER_LIMIT,  32'd1, $urandom, $urandom);
    issue(lcgr_pkg::OPER_LIMIT,  '0, $urandom, $urandom);               // zero limit
    issue(lcgr_pkg::OPER_LIMIT,  lcgr_pkg::ALL_ONES, $urandom, $urandom);
    issue(lcgr_pkg::OPER_LIMIT,  32'h8000_0001, $urandom, $urandom);    // rejection loop
    issue(lcgr_pkg::OPER_LIMIT,  32'h8000_0000, $urandom, $urandom);
    issue(lcgr_pkg::OPER_LIMIT,  32'd7, $urandom, $urandom);
    issue(lcgr_pkg::OPER_RANGE,  $urandom, lcgr_pkg::ALL_ONES, lcgr_pkg::ALL_ONES);
    issue(lcgr_pkg::OPER_RANGE,  $urandom, 32'h8000_0000, 32'hFFFF_FFFE); // widest legal
    issue(lcgr_pkg::OPER_RANGE,  $urandom, 32'h8000_0000, lcgr_pkg::ALL_ONES); // too wide
    issue(lcgr_pkg::OPER_RANGE,  $urandom, 32'h8000_0000, 32'h7FFF_FFFF); // full width
    issue(lcgr_pkg::OPER_RANGE,  $urandom, 32'd5, -32'sd5);             // inverted
    issue(lcgr_pkg::OPER_RANGE,  $urandom, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(lcgr_pkg::OPER_RANGE,  $urandom, -32'sd5, 32'd5);
    issue(lcgr_pkg::OPER_RANGE,  $urandom, 32'd1, 32'h7FFF_FFFF);
    issue(lcgr_pkg::OPER_RANGE,  $urandom, '0, 32'h7FFF_FFFF);          // wide by one
    issue(OPER_UNUSED, '0, '0, '0);
    issue(OPER_UNUSED, lcgr_pkg::ALL_ONES, lcgr_pkg::ALL_ONES, lcgr_pkg::ALL_ONES);
    issue(lcgr_pkg::OPER_RAW, lcgr_pkg::ALL_ONES, lcgr_pkg::ALL_ONES, lcgr_pkg::ALL_ONES);

    // Random phases, each after a full drain and a new register setting.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_regs(1'b1, lcgr_pkg::PRESET_GLIBC,   1'b1, lcgr_pkg::ALL_ONES);
        1: set_regs(1'b1, lcgr_pkg::PRESET_GLIBC31, 1'b1, 32'h8000_0000);
        2: set_regs(1'b1, PRESET_ALIAS,   1'b1, $urandom);
        3: set_regs(1'b0, PRESET_MSVC,    1'b1, $urandom);  // preset kept
        4: set_regs(1'b1, PRESET_MSVC,    1'b0, '0);        // state kept
        5: set_regs(1'b1, lcgr_pkg::PRESET_GLIBC31, 1'b1, '0);
        6: set_regs(1'b1, lcgr_pkg::PRESET_GLIBC,   1'b1, $urandom);
        default: set_regs(1'b1, PRESET_MSVC, 1'b1, 32'h7FFF_FFFF);
      endcase
      calm = (ph == 6);
      if (ph == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_request();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests (%0d flagged invalid), %0d results checked, %0d redraws",
             tracker.requests, tracker.error_results, tracker.checked, tracker.rejected_draws);
    $display("all four preset codes, seed and preset writes alone and together, %0d-cycle stall",
             HOLD_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
